// ----- hw/rtl/htdp_pkg.sv -----
// shared types and codes for the handle table dense packing core
// used by the controller, the datapath and the top level; no dependencies

package htdp_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DEAD = 2'd2
  } status_e;

  localparam int unsigned HandleW = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned RecIoW  = 32;

  // controller to datapath
  typedef struct packed {
    logic accept;    // latch the transaction and issue the lookup reads
    logic commit;    // update the tables and load the result register
    logic rd_issue;  // read the record store at the looked-up position
    logic rd_load;   // load the result register with the read data
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
  } dp_status_t;

endpackage

// ----- hw/rtl/handle_table_dense_packing_core.sv -----
// top level of the handle table dense packing core (slot map)
// depends on htdp_pkg, htdp_ctrl and htdp_datapath
//
// Slot map: records stay packed at positions 0 to live_count-1 and are reached
// through stable handles. One transaction is in progress at a time. Every
// table is a single-port-read memory with registered read data, so a
// transaction first makes the lookup reads on acceptance (handle map, live
// map, owner of the last record, top of the free stack, last record) and then
// the table updates, which for insert, erase and write also load the result
// register. A read of a live handle instead makes a second access to the
// record store at the looked-up position and then loads the result register.
// The next transaction is accepted in the cycle after the result is loaded. A
// result waiting in the output register does not hold up acceptance, but the
// next transaction waits at its update, or a read at its result load, until
// the receiver takes that result. The tables need no clearing after reset: a
// handle counts as live only below the count of handles issued so far, so the
// block is ready straight out of reset.

module handle_table_dense_packing_core #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned RECORD_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic [htdp_pkg::HandleW-1:0] handle_i,
  input  logic [htdp_pkg::RecIoW-1:0]  record_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [htdp_pkg::HandleW-1:0] handle_out_o,
  output logic [htdp_pkg::HandleW-1:0] dense_index_o,
  output logic [htdp_pkg::RecIoW-1:0]  record_out_o,
  output logic [htdp_pkg::CountW-1:0]  live_count_o
);

  htdp_pkg::ctrl_cmd_t  dp_cmd;
  htdp_pkg::dp_status_t dp_stat;

  htdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  htdp_datapath #(
    .CAPACITY     (CAPACITY),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .dp_stat_o     (dp_stat),
    .cmd_i         (cmd_i),
    .handle_i      (handle_i),
    .record_in_i   (record_in_i),
    .status_o      (status_o),
    .handle_out_o  (handle_out_o),
    .dense_index_o (dense_index_o),
    .record_out_o  (record_out_o),
    .live_count_o  (live_count_o)
  );

endmodule

// ----- hw/rtl/htdp_ctrl.sv -----
// sequencing controller for the handle table dense packing core
// depends on htdp_pkg; drives the datapath through htdp_pkg::ctrl_cmd_t

module htdp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  htdp_pkg::dp_status_t dp_stat_i,
  output htdp_pkg::ctrl_cmd_t  dp_cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RDATA
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    dp_cmd_o          = '0;
    state_d           = state_q;
    out_valid_d       = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.accept = 1'b1;
          state_d         = S_LOOK;
        end
      end
      S_LOOK: begin
        if (dp_stat_i.need_read) begin
          dp_cmd_o.rd_issue = 1'b1;
          state_d           = S_RDATA;
        end else if (out_free) begin
          dp_cmd_o.commit = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RDATA: begin
        if (out_free) begin
          dp_cmd_o.rd_load = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/htdp_datapath.sv -----
// tables, counters and result register of the handle table dense packing core
// depends on htdp_pkg; controlled by htdp_ctrl through htdp_pkg::ctrl_cmd_t

module htdp_datapath #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned RECORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  htdp_pkg::ctrl_cmd_t               dp_cmd_i,
  output htdp_pkg::dp_status_t              dp_stat_o,
  input  logic [1:0]                        cmd_i,
  input  logic [htdp_pkg::HandleW-1:0]      handle_i,
  input  logic [htdp_pkg::RecIoW-1:0]       record_in_i,
  output logic [1:0]                        status_o,
  output logic [htdp_pkg::HandleW-1:0]      handle_out_o,
  output logic [htdp_pkg::HandleW-1:0]      dense_index_o,
  output logic [htdp_pkg::RecIoW-1:0]       record_out_o,
  output logic [htdp_pkg::CountW-1:0]       live_count_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > htdp_pkg::HandleW) ? CW : htdp_pkg::HandleW;

  // memories
  logic [RECORD_WIDTH-1:0] rec_mem   [CAPACITY];
  logic [AW-1:0]           owner_mem [CAPACITY];
  logic [AW-1:0]           h2d_mem   [CAPACITY];
  logic                    live_mem  [CAPACITY];
  logic [AW-1:0]           stack_mem [CAPACITY];

  // counters
  logic [CW-1:0] live_q, live_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] issued_q, issued_d;

  // latched transaction
  htdp_pkg::cmd_e                  cmd_q;
  logic [htdp_pkg::HandleW-1:0]    handle_q;
  logic [RECORD_WIDTH-1:0]         rec_q;

  // registered read data
  logic [RECORD_WIDTH-1:0] rec_rd_q;
  logic [AW-1:0]           owner_rd_q;
  logic [AW-1:0]           h2d_rd_q;
  logic                    live_rd_q;
  logic [AW-1:0]           top_rd_q;

  // result register
  htdp_pkg::status_e            status_q;
  logic [htdp_pkg::HandleW-1:0] handle_out_q;
  logic [htdp_pkg::HandleW-1:0] dense_q;
  logic [htdp_pkg::RecIoW-1:0]  rec_out_q;
  logic [htdp_pkg::CountW-1:0]  count_q;

  logic [AW-1:0]           in_addr;
  logic [AW-1:0]           last_idx;
  logic [AW-1:0]           top_idx;
  logic [AW-1:0]           h_addr;
  logic [AW-1:0]           live_idx;
  logic [AW-1:0]           new_handle;
  logic                    is_live;
  logic                    full;
  logic                    op_ok;

  logic                    rec_we, owner_we, h2d_we, live_we, stack_we, rec_re;
  logic [AW-1:0]           rec_wa, owner_wa, h2d_wa, live_wa, rec_ra;
  logic [RECORD_WIDTH-1:0] rec_wd;
  logic [AW-1:0]           owner_wd, h2d_wd;
  logic                    live_wd;

  htdp_pkg::status_e            status_d;
  logic [htdp_pkg::HandleW-1:0] handle_out_d;
  logic [htdp_pkg::HandleW-1:0] dense_d;

  assign in_addr    = AW'(handle_i);
  assign last_idx   = AW'(live_q - CW'(1));
  assign top_idx    = AW'(free_q - CW'(1));
  assign h_addr     = AW'(handle_q);
  assign live_idx   = AW'(live_q);
  assign new_handle = (free_q != '0) ? top_rd_q : AW'(issued_q);

  // a handle at or above the issue count was never written in the live map
  assign is_live = live_rd_q && (CMPW'(handle_q) < CMPW'(issued_q));
  assign full    = (live_q == CW'(CAPACITY));
  assign op_ok   = (cmd_q == htdp_pkg::CMD_INSERT) ? !full : is_live;

  assign dp_stat_o.need_read = (cmd_q == htdp_pkg::CMD_READ) && is_live;

  // table writes and counter updates on commit
  always_comb begin
    rec_we   = 1'b0;
    rec_wa   = h2d_rd_q;
    rec_wd   = rec_q;
    owner_we = 1'b0;
    owner_wa = live_idx;
    owner_wd = new_handle;
    h2d_we   = 1'b0;
    h2d_wa   = new_handle;
    h2d_wd   = live_idx;
    live_we  = 1'b0;
    live_wa  = new_handle;
    live_wd  = 1'b1;
    stack_we = 1'b0;
    live_d   = live_q;
    free_d   = free_q;
    issued_d = issued_q;
    if (dp_cmd_i.commit && op_ok) begin
      case (cmd_q)
        htdp_pkg::CMD_INSERT: begin
          rec_we   = 1'b1;
          rec_wa   = live_idx;
          owner_we = 1'b1;
          h2d_we   = 1'b1;
          live_we  = 1'b1;
          live_d   = live_q + CW'(1);
          if (free_q != '0) begin
            free_d = free_q - CW'(1);
          end else begin
            issued_d = issued_q + CW'(1);
          end
        end
        htdp_pkg::CMD_ERASE: begin
          // move the last record into the hole
          rec_we   = 1'b1;
          rec_wd   = rec_rd_q;
          owner_we = 1'b1;
          owner_wa = h2d_rd_q;
          owner_wd = owner_rd_q;
          h2d_we   = 1'b1;
          h2d_wa   = owner_rd_q;
          h2d_wd   = h2d_rd_q;
          live_we  = 1'b1;
          live_wa  = h_addr;
          live_wd  = 1'b0;
          stack_we = 1'b1;
          free_d   = free_q + CW'(1);
          live_d   = live_q - CW'(1);
        end
        htdp_pkg::CMD_WRITE: begin
          rec_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // record store read port serves the last record on accept, the target on a read
  assign rec_re = dp_cmd_i.accept || dp_cmd_i.rd_issue;
  assign rec_ra = dp_cmd_i.accept ? last_idx : h2d_rd_q;

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      owner_mem[owner_wa] <= owner_wd;
    end
    if (dp_cmd_i.accept) begin
      owner_rd_q <= owner_mem[last_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (h2d_we) begin
      h2d_mem[h2d_wa] <= h2d_wd;
    end
    if (dp_cmd_i.accept) begin
      h2d_rd_q <= h2d_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (dp_cmd_i.accept) begin
      live_rd_q <= live_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[AW'(free_q)] <= h_addr;
    end
    if (dp_cmd_i.accept) begin
      top_rd_q <= stack_mem[top_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.accept) begin
      cmd_q    <= htdp_pkg::cmd_e'(cmd_i);
      handle_q <= handle_i;
      rec_q    <= RECORD_WIDTH'(record_in_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= '0;
      free_q   <= '0;
      issued_q <= '0;
    end else begin
      live_q   <= live_d;
      free_q   <= free_d;
      issued_q <= issued_d;
    end
  end

  // result fields of a committed transaction
  always_comb begin
    status_d     = htdp_pkg::ST_OK;
    handle_out_d = handle_q;
    dense_d      = htdp_pkg::HandleW'(h2d_rd_q);
    if (cmd_q == htdp_pkg::CMD_INSERT) begin
      if (full) begin
        status_d     = htdp_pkg::ST_FULL;
        handle_out_d = '0;
        dense_d      = '0;
      end else begin
        handle_out_d = htdp_pkg::HandleW'(new_handle);
        dense_d      = htdp_pkg::HandleW'(live_q);
      end
    end else if (!is_live) begin
      status_d = htdp_pkg::ST_DEAD;
      dense_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.commit) begin
      status_q     <= status_d;
      handle_out_q <= handle_out_d;
      dense_q      <= dense_d;
      rec_out_q    <= '0;
      count_q      <= htdp_pkg::CountW'(live_d);
    end else if (dp_cmd_i.rd_load) begin
      status_q     <= htdp_pkg::ST_OK;
      handle_out_q <= handle_q;
      dense_q      <= htdp_pkg::HandleW'(h2d_rd_q);
      rec_out_q    <= htdp_pkg::RecIoW'(rec_rd_q);
      count_q      <= htdp_pkg::CountW'(live_q);
    end
  end

  assign status_o      = status_q;
  assign handle_out_o  = handle_out_q;
  assign dense_index_o = dense_q;
  assign record_out_o  = rec_out_q;
  assign live_count_o  = count_q;

endmodule
